FILE: rtl/crfe_pkg.sv
// crfe_pkg: command codes, controller states and fixed constants of the
// clipped rectangle fill engine. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package crfe_pkg;

  // command codes carried on func_i
  typedef enum logic [2:0] {
    CMD_CLEAR  = 3'd0,
    CMD_SET    = 3'd1,
    CMD_FILL   = 3'd2,
    CMD_BORDER = 3'd3,
    CMD_READ   = 3'd4
  } cmd_e;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_FILL,
    ST_READ
  } state_e;

  // alpha byte of every drawn pixel
  localparam logic [31:0] ALPHA_OPAQUE = 32'hFF00_0000;

  // width of signed coordinate sums, holds x + w - t without wrap
  localparam int CoordW = 20;

endpackage

`default_nettype wire

FILE: rtl/clipped_rectangle_fill_engine.sv
// Clipped rectangle fill engine: controller, clipping and frame store.
// Depends on crfe_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Drawing engine over a CANVAS_WIDTH x CANVAS_HEIGHT frame of 32-bit pixels
// (alpha 255, blue, green, red from the high byte down).
// Input channel (in_valid_i / in_ready_o) takes one command per transaction;
// the output channel (out_valid_o / out_ready_i) returns exactly one result
// per command, in order, from an output register.
// The output register loads a result on acceptance; a read on the canvas
// loads it from the read state that follows acceptance.
// Commands are taken one at a time; the frame store's write port takes one
// pixel per cycle, and its read port is registered. Per command:
//   unused code, or set or read off the canvas: straight back to idle;
//   set pixel: a one by one fill; read on the canvas: the read state;
//   fill: a setup step, then the clipped area; border: a setup step and
//   the clipped area for each of its four parts; clear: the whole canvas.
// Reset: after rst_ni rises, a clearing pass writes zero to every pixel
// with in_ready_o low.
// Stall: a result waiting on out_ready_i keeps the next command out only
// until it is taken; a fill keeps drawing whatever the receiver does.
module clipped_rectangle_fill_engine #(
  parameter int CANVAS_WIDTH  = 256,
  parameter int CANVAS_HEIGHT = 256
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [2:0]         func_i,
  input  wire logic signed [15:0] pos_x_i,
  input  wire logic signed [15:0] pos_y_i,
  input  wire logic signed [15:0] rect_width_i,
  input  wire logic signed [15:0] rect_height_i,
  input  wire logic signed [15:0] border_thickness_i,
  input  wire logic [7:0]         red_i,
  input  wire logic [7:0]         green_i,
  input  wire logic [7:0]         blue_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [31:0]             pixel_value_o,
  output logic                    in_range_o
);

  localparam int Depth = CANVAS_WIDTH * CANVAS_HEIGHT;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int XW    = $clog2(CANVAS_WIDTH + 1);
  localparam int YW    = $clog2(CANVAS_HEIGHT + 1);
  localparam int CW    = crfe_pkg::CoordW;
  localparam logic signed [CW-1:0] WS = CW'(CANVAS_WIDTH);
  localparam logic signed [CW-1:0] HS = CW'(CANVAS_HEIGHT);

  crfe_pkg::state_e state_q, state_d;

  // fill walker and command registers
  logic [XW-1:0]        ix_q, x0_q, x1_q;
  logic [YW-1:0]        iy_q, y1_q;
  logic [31:0]          color_q;
  logic [1:0]           phase_q;
  logic                 border_q;
  logic signed [15:0]   px_q, py_q, pw_q, ph_q, pt_q;

  // output register
  logic                 out_valid_q;
  logic [31:0]          pixel_q;
  logic                 in_range_q;

  // frame store
  logic [31:0]          mem_q [Depth];
  logic [31:0]          rdata_q;
  logic [AW-1:0]        wr_addr, rd_addr;
  logic                 wr_en;

  logic                 accept;
  crfe_pkg::cmd_e       cmd;
  logic [31:0]          color_in;
  logic                 on_canvas;
  logic                 row_end, last_px, last_phase;

  // clipping of the current rectangle
  logic signed [CW-1:0] rx, ry, rw, rh, ex, ey, cx0, cy0, cx1, cy1;
  logic                 empty;

  assign cmd        = crfe_pkg::cmd_e'(func_i);
  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == crfe_pkg::ST_IDLE) && (!out_valid_q || out_ready_i);
  assign color_in   = crfe_pkg::ALPHA_OPAQUE | {8'd0, blue_i, green_i, red_i};
  assign on_canvas  = (pos_x_i >= 16'sd0) && (17'(pos_x_i) < 17'(CANVAS_WIDTH)) &&
                      (pos_y_i >= 16'sd0) && (17'(pos_y_i) < 17'(CANVAS_HEIGHT));

  assign row_end    = (ix_q + XW'(1)) == x1_q;
  assign last_px    = row_end && ((iy_q + YW'(1)) == y1_q);
  assign last_phase = !border_q || (phase_q == 2'd3);

  // pick the rectangle of this phase: a fill has one, a border four
  always_comb begin
    rx = CW'(px_q);
    ry = CW'(py_q);
    rw = CW'(pw_q);
    rh = CW'(ph_q);
    if (border_q) begin
      case (phase_q)
        2'd0: rh = CW'(pt_q);
        2'd1: begin
          ry = CW'(py_q) + CW'(ph_q) - CW'(pt_q);
          rh = CW'(pt_q);
        end
        2'd2: rw = CW'(pt_q);
        default: begin
          rx = CW'(px_q) + CW'(pw_q) - CW'(pt_q);
          rw = CW'(pt_q);
        end
      endcase
    end
    ex    = rx + rw;
    ey    = ry + rh;
    cx0   = (rx < 0) ? '0 : rx;
    cy0   = (ry < 0) ? '0 : ry;
    cx1   = (ex > WS) ? WS : ex;
    cy1   = (ey > HS) ? HS : ey;
    empty = (cx0 >= WS) || (cy0 >= HS) || (cx1 <= 0) || (cy1 <= 0) ||
            (cx1 <= cx0) || (cy1 <= cy0);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      crfe_pkg::ST_IDLE: begin
        if (accept) begin
          case (cmd)
            crfe_pkg::CMD_CLEAR:  state_d = crfe_pkg::ST_FILL;
            crfe_pkg::CMD_SET:    state_d = on_canvas ? crfe_pkg::ST_FILL : crfe_pkg::ST_IDLE;
            crfe_pkg::CMD_FILL,
            crfe_pkg::CMD_BORDER: state_d = crfe_pkg::ST_SETUP;
            crfe_pkg::CMD_READ:   state_d = on_canvas ? crfe_pkg::ST_READ : crfe_pkg::ST_IDLE;
            default:              state_d = crfe_pkg::ST_IDLE;
          endcase
        end
      end
      crfe_pkg::ST_SETUP: begin
        if (!empty) begin
          state_d = crfe_pkg::ST_FILL;
        end else if (last_phase) begin
          state_d = crfe_pkg::ST_IDLE;
        end
      end
      crfe_pkg::ST_FILL: begin
        if (last_px) begin
          state_d = last_phase ? crfe_pkg::ST_IDLE : crfe_pkg::ST_SETUP;
        end
      end
      crfe_pkg::ST_READ: state_d = crfe_pkg::ST_IDLE;
      default:           state_d = crfe_pkg::ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= crfe_pkg::ST_FILL;
    end else begin
      state_q <= state_d;
    end
  end

  // walker, bounds and command registers; reset starts the clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ix_q     <= '0;
      iy_q     <= '0;
      x0_q     <= '0;
      x1_q     <= XW'(CANVAS_WIDTH);
      y1_q     <= YW'(CANVAS_HEIGHT);
      color_q  <= '0;
      phase_q  <= '0;
      border_q <= 1'b0;
    end else begin
      case (state_q)
        crfe_pkg::ST_IDLE: begin
          if (accept) begin
            color_q  <= color_in;
            phase_q  <= '0;
            border_q <= (cmd == crfe_pkg::CMD_BORDER);
            if (cmd == crfe_pkg::CMD_CLEAR) begin
              ix_q <= '0;
              iy_q <= '0;
              x0_q <= '0;
              x1_q <= XW'(CANVAS_WIDTH);
              y1_q <= YW'(CANVAS_HEIGHT);
            end else begin
              // single pixel as a one by one fill
              ix_q <= pos_x_i[XW-1:0];
              iy_q <= pos_y_i[YW-1:0];
              x0_q <= pos_x_i[XW-1:0];
              x1_q <= pos_x_i[XW-1:0] + XW'(1);
              y1_q <= pos_y_i[YW-1:0] + YW'(1);
            end
          end
        end
        crfe_pkg::ST_SETUP: begin
          if (empty) begin
            phase_q <= phase_q + 2'd1;
          end else begin
            ix_q <= cx0[XW-1:0];
            iy_q <= cy0[YW-1:0];
            x0_q <= cx0[XW-1:0];
            x1_q <= cx1[XW-1:0];
            y1_q <= cy1[YW-1:0];
          end
        end
        crfe_pkg::ST_FILL: begin
          if (row_end) begin
            ix_q <= x0_q;
            iy_q <= iy_q + YW'(1);
          end else begin
            ix_q <= ix_q + XW'(1);
          end
          if (last_px) begin
            phase_q <= phase_q + 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // rectangle parameters of the accepted command
  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q <= pos_x_i;
      py_q <= pos_y_i;
      pw_q <= rect_width_i;
      ph_q <= rect_height_i;
      pt_q <= border_thickness_i;
    end
  end

  // frame store: one write port driven by the walker, one read port
  assign wr_en   = (state_q == crfe_pkg::ST_FILL);
  assign wr_addr = AW'(AW'(iy_q) * AW'(CANVAS_WIDTH) + AW'(ix_q));
  assign rd_addr = AW'(AW'($unsigned(pos_y_i)) * AW'(CANVAS_WIDTH) +
                       AW'($unsigned(pos_x_i)));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= color_q;
    end
    if (accept) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // output register: results load on acceptance, reads on the canvas in the cycle after
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept && !(cmd == crfe_pkg::CMD_READ && on_canvas)) begin
      out_valid_q <= 1'b1;
    end else if (state_q == crfe_pkg::ST_READ) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pixel_q    <= '0;
      in_range_q <= on_canvas &&
                    (cmd == crfe_pkg::CMD_SET || cmd == crfe_pkg::CMD_READ);
    end else if (state_q == crfe_pkg::ST_READ) begin
      pixel_q <= rdata_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_value_o = pixel_q;
  assign in_range_o    = in_range_q;

  // every accepted command yields a result next cycle or waits on its read
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (out_valid_q || state_q == crfe_pkg::ST_READ))
    else $error("accepted transaction produced no result");

  // a pending read always delivers in the next cycle
  a_read_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == crfe_pkg::ST_READ) |=> out_valid_q)
    else $error("read result not delivered");

  // the walker never leaves the clipped bounds
  a_walker_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == crfe_pkg::ST_FILL) |-> (ix_q < x1_q && iy_q < y1_q &&
                                        x1_q <= XW'(CANVAS_WIDTH)))
    else $error("fill walker out of bounds");

endmodule

`default_nettype wire
